### design/i2cmbe_pkg.sv
// Package for the I2C master byte engine: payload structs, command and
// phase codes, register indexes and shared constants.
// No dependencies.
`timescale 1ns / 1ps

package i2cmbe_pkg;

  // Default width of the phase delay counter.
  localparam int DELAY_COUNT_WIDTH_DEF = 10;
  // Width used to form and saturate a delay load (covers widths up to 16).
  localparam int DLY_CALC_W = 17;

  // Reset values of the configuration registers.
  localparam logic [7:0] TICKS_PER_US_RST = 8'd8;
  localparam logic [7:0] ACK_TIMEOUT_RST  = 8'd250;

  // Configuration register indexes.
  localparam logic CFG_TICKS_PER_US = 1'b0;
  localparam logic CFG_ACK_TIMEOUT  = 1'b1;

  // Opcode field values.
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_WAIT  = 3'd5;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ,
    CMD_WAIT
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_SP_A,
    PH_SP_B,
    PH_SP_C,
    PH_WA_A,
    PH_WA_B,
    PH_WA_POLL,
    PH_TX_A,
    PH_TX_B,
    PH_TX_C,
    PH_RX_A,
    PH_RX_B,
    PH_AK_A,
    PH_AK_B
  } phase_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_oe;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack;
  } out_item_t;

  // A tick after classification, as it waits in the front queue.
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

  // Front queue head as seen by the sequencer.
  typedef struct packed {
    logic  valid;
    tick_t tick;
  } tick_chan_t;

  // Sequencer result toward the output queue.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_chan_t;

endpackage

### design/i2cmbe_front.sv
// Front part of the I2C master byte engine: decodes each incoming tick's
// opcode and holds the tick in a two-entry queue. Depends on i2cmbe_pkg.
`timescale 1ns / 1ps

module i2cmbe_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  i2cmbe_pkg::in_item_t  in_item,
  output logic                  full,
  output i2cmbe_pkg::tick_chan_t head,
  input  logic                  take
);

  i2cmbe_pkg::tick_t mem [2];
  i2cmbe_pkg::tick_t tick_dec;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  // Unused opcodes become no command.
  always_comb begin
    tick_dec.tx_byte  = in_item.tx_byte;
    tick_dec.send_ack = in_item.send_ack;
    tick_dec.sda_in   = in_item.sda_in;
    unique case (in_item.opcode)
      i2cmbe_pkg::OP_START: tick_dec.cmd = i2cmbe_pkg::CMD_START;
      i2cmbe_pkg::OP_STOP:  tick_dec.cmd = i2cmbe_pkg::CMD_STOP;
      i2cmbe_pkg::OP_WRITE: tick_dec.cmd = i2cmbe_pkg::CMD_WRITE;
      i2cmbe_pkg::OP_READ:  tick_dec.cmd = i2cmbe_pkg::CMD_READ;
      i2cmbe_pkg::OP_WAIT:  tick_dec.cmd = i2cmbe_pkg::CMD_WAIT;
      default:              tick_dec.cmd = i2cmbe_pkg::CMD_NONE;
    endcase
  end

  assign full       = (count_r == 2'd2);
  assign do_push    = push && !full;
  assign do_pop     = take && (count_r != 2'd0);
  assign head.valid = (count_r != 2'd0);
  assign head.tick  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= tick_dec;
    end
  end

endmodule

### design/i2cmbe_seq.sv
// Back part of the I2C master byte engine: the phase sequencer with its bit,
// shift, delay and timeout registers and the two configuration registers.
// Depends on i2cmbe_pkg.
`timescale 1ns / 1ps

module i2cmbe_seq #(
  parameter int DELAY_COUNT_WIDTH = i2cmbe_pkg::DELAY_COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [7:0]             cfg_wdata,
  input  i2cmbe_pkg::tick_chan_t head,
  output logic                   take,
  input  logic                   res_full,
  output i2cmbe_pkg::res_chan_t  res
);

  localparam int DW = DELAY_COUNT_WIDTH;

  i2cmbe_pkg::phase_t phase_r, phase_nxt, ent;
  logic [3:0]    bit_count_r, bit_count_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [DW-1:0] delay_r, delay_nxt;
  logic [7:0]    timeout_r, timeout_nxt;
  logic          ack_choice_r, ack_choice_nxt;
  logic          scl_r, scl_nxt, sda_r, sda_nxt, oe_r, oe_nxt;
  logic [7:0]    rx_hold_r, rx_hold_nxt;
  logic          nack_r, nack_nxt;
  logic [7:0]    tpu_r, ato_r;
  logic          done, en;
  logic [DW-1:0] dly1, dly2, dly4;
  i2cmbe_pkg::tick_t tk;

  // Delay load saturated to the counter's full scale.
  function automatic logic [DW-1:0] sat_delay(input logic [9:0] v);
    logic [i2cmbe_pkg::DLY_CALC_W-1:0] w;
    w = {{(i2cmbe_pkg::DLY_CALC_W - 10){1'b0}}, v};
    if ((w >> DW) != '0) begin
      sat_delay = '1;
    end else begin
      sat_delay = w[DW-1:0];
    end
  endfunction

  assign dly1 = sat_delay({2'b00, tpu_r});
  assign dly2 = sat_delay({1'b0, tpu_r, 1'b0});
  assign dly4 = sat_delay({tpu_r, 2'b00});

  assign tk   = head.tick;
  assign take = head.valid && !res_full;

  always_comb begin
    phase_nxt      = phase_r;
    bit_count_nxt  = bit_count_r;
    shift_nxt      = shift_r;
    delay_nxt      = delay_r;
    timeout_nxt    = timeout_r;
    ack_choice_nxt = ack_choice_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    oe_nxt         = oe_r;
    rx_hold_nxt    = rx_hold_r;
    nack_nxt       = nack_r;
    done           = 1'b0;
    en             = 1'b0;
    ent            = i2cmbe_pkg::PH_IDLE;

    if (take) begin
      unique case (phase_r)
        i2cmbe_pkg::PH_IDLE: begin
          unique case (tk.cmd)
            i2cmbe_pkg::CMD_START: begin
              en = 1'b1; ent = i2cmbe_pkg::PH_ST_A;
            end
            i2cmbe_pkg::CMD_STOP: begin
              en = 1'b1; ent = i2cmbe_pkg::PH_SP_A;
            end
            i2cmbe_pkg::CMD_WRITE: begin
              shift_nxt = tk.tx_byte; bit_count_nxt = 4'd0;
              en = 1'b1; ent = i2cmbe_pkg::PH_TX_A;
            end
            i2cmbe_pkg::CMD_READ: begin
              shift_nxt = 8'd0; bit_count_nxt = 4'd0; ack_choice_nxt = tk.send_ack;
              en = 1'b1; ent = i2cmbe_pkg::PH_RX_A;
            end
            i2cmbe_pkg::CMD_WAIT: begin
              en = 1'b1; ent = i2cmbe_pkg::PH_WA_A;
            end
            default: ;
          endcase
        end
        i2cmbe_pkg::PH_WA_POLL: begin
          if (!tk.sda_in) begin
            scl_nxt = 1'b0; nack_nxt = 1'b0;
            phase_nxt = i2cmbe_pkg::PH_IDLE; done = 1'b1;
          end else if (timeout_r >= ato_r) begin
            nack_nxt = 1'b1;
            en = 1'b1; ent = i2cmbe_pkg::PH_SP_A;
          end else begin
            timeout_nxt = timeout_r + 8'd1;
          end
        end
        default: begin
          if (delay_r > DW'(1)) begin
            delay_nxt = delay_r - DW'(1);
          end else begin
            unique case (phase_r)
              i2cmbe_pkg::PH_ST_A: begin en = 1'b1; ent = i2cmbe_pkg::PH_ST_B; end
              i2cmbe_pkg::PH_SP_A: begin en = 1'b1; ent = i2cmbe_pkg::PH_SP_B; end
              i2cmbe_pkg::PH_SP_B: begin en = 1'b1; ent = i2cmbe_pkg::PH_SP_C; end
              i2cmbe_pkg::PH_WA_A: begin en = 1'b1; ent = i2cmbe_pkg::PH_WA_B; end
              i2cmbe_pkg::PH_WA_B: begin en = 1'b1; ent = i2cmbe_pkg::PH_WA_POLL; end
              i2cmbe_pkg::PH_TX_A: begin en = 1'b1; ent = i2cmbe_pkg::PH_TX_B; end
              i2cmbe_pkg::PH_TX_B: begin en = 1'b1; ent = i2cmbe_pkg::PH_TX_C; end
              i2cmbe_pkg::PH_RX_A: begin en = 1'b1; ent = i2cmbe_pkg::PH_RX_B; end
              i2cmbe_pkg::PH_AK_A: begin en = 1'b1; ent = i2cmbe_pkg::PH_AK_B; end
              i2cmbe_pkg::PH_TX_C: begin
                shift_nxt     = {shift_r[6:0], 1'b0};
                bit_count_nxt = bit_count_r + 4'd1;
                if (bit_count_nxt >= 4'd8) begin
                  phase_nxt = i2cmbe_pkg::PH_IDLE; done = 1'b1;
                end else begin
                  en = 1'b1; ent = i2cmbe_pkg::PH_TX_A;
                end
              end
              i2cmbe_pkg::PH_RX_B: begin
                bit_count_nxt = bit_count_r + 4'd1;
                if (bit_count_nxt >= 4'd8) begin
                  rx_hold_nxt = shift_r;
                  en = 1'b1; ent = i2cmbe_pkg::PH_AK_A;
                end else begin
                  en = 1'b1; ent = i2cmbe_pkg::PH_RX_A;
                end
              end
              i2cmbe_pkg::PH_ST_B, i2cmbe_pkg::PH_AK_B: begin
                scl_nxt = 1'b0;
                phase_nxt = i2cmbe_pkg::PH_IDLE; done = 1'b1;
              end
              default: begin
                phase_nxt = i2cmbe_pkg::PH_IDLE; done = 1'b1;
              end
            endcase
          end
        end
      endcase
    end

    // Phase entry: set the lines and load the phase delay.
    if (en) begin
      phase_nxt = ent;
      unique case (ent)
        i2cmbe_pkg::PH_ST_A: begin
          oe_nxt = 1'b1; sda_nxt = 1'b1; scl_nxt = 1'b1; delay_nxt = dly4;
        end
        i2cmbe_pkg::PH_ST_B: begin sda_nxt = 1'b0; delay_nxt = dly4; end
        i2cmbe_pkg::PH_SP_A: begin
          oe_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = 1'b0; delay_nxt = dly4;
        end
        i2cmbe_pkg::PH_SP_B: begin scl_nxt = 1'b1; delay_nxt = dly1; end
        i2cmbe_pkg::PH_SP_C: begin sda_nxt = 1'b1; delay_nxt = dly4; end
        i2cmbe_pkg::PH_WA_A: begin
          oe_nxt = 1'b0; sda_nxt = 1'b1; timeout_nxt = 8'd0; delay_nxt = dly1;
        end
        i2cmbe_pkg::PH_WA_B:    begin scl_nxt = 1'b1; delay_nxt = dly1; end
        i2cmbe_pkg::PH_WA_POLL: delay_nxt = '0;
        i2cmbe_pkg::PH_TX_A: begin
          oe_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = shift_nxt[7]; delay_nxt = dly2;
        end
        i2cmbe_pkg::PH_TX_B: begin scl_nxt = 1'b1; delay_nxt = dly2; end
        i2cmbe_pkg::PH_TX_C: begin scl_nxt = 1'b0; delay_nxt = dly2; end
        i2cmbe_pkg::PH_RX_A: begin oe_nxt = 1'b0; scl_nxt = 1'b0; delay_nxt = dly2; end
        i2cmbe_pkg::PH_RX_B: begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_nxt[6:0], tk.sda_in};
          delay_nxt = dly1;
        end
        i2cmbe_pkg::PH_AK_A: begin
          scl_nxt = 1'b0; oe_nxt = 1'b1; sda_nxt = !ack_choice_nxt; delay_nxt = dly2;
        end
        i2cmbe_pkg::PH_AK_B: begin scl_nxt = 1'b1; delay_nxt = dly2; end
        default: phase_nxt = i2cmbe_pkg::PH_IDLE;
      endcase
    end
  end

  assign res.valid         = take;
  assign res.item.scl      = scl_nxt;
  assign res.item.sda_out  = sda_nxt;
  assign res.item.sda_oe   = oe_nxt;
  assign res.item.busy_res = (phase_nxt != i2cmbe_pkg::PH_IDLE);
  assign res.item.done_res = done;
  assign res.item.rx_byte  = rx_hold_nxt;
  assign res.item.nack     = nack_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= i2cmbe_pkg::PH_IDLE;
      bit_count_r  <= 4'd0;
      shift_r      <= 8'd0;
      delay_r      <= '0;
      timeout_r    <= 8'd0;
      ack_choice_r <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      oe_r         <= 1'b1;
      rx_hold_r    <= 8'd0;
      nack_r       <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      bit_count_r  <= bit_count_nxt;
      shift_r      <= shift_nxt;
      delay_r      <= delay_nxt;
      timeout_r    <= timeout_nxt;
      ack_choice_r <= ack_choice_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      oe_r         <= oe_nxt;
      rx_hold_r    <= rx_hold_nxt;
      nack_r       <= nack_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r <= i2cmbe_pkg::TICKS_PER_US_RST;
      ato_r <= i2cmbe_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cmbe_pkg::CFG_TICKS_PER_US: tpu_r <= cfg_wdata;
        i2cmbe_pkg::CFG_ACK_TIMEOUT:  ato_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

### design/i2cmbe_outq.sv
// Result queue of the I2C master byte engine: two entries between the
// sequencer and the output port. Depends on i2cmbe_pkg.
`timescale 1ns / 1ps

module i2cmbe_outq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  i2cmbe_pkg::res_chan_t  res,
  output logic                   res_full,
  output logic                   empty,
  input  logic                   pop,
  output i2cmbe_pkg::out_item_t  out_item
);

  i2cmbe_pkg::out_item_t mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign res_full = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = res.valid && !res_full;
  assign do_pop   = pop && !empty;
  assign out_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= res.item;
    end
  end

endmodule

### design/i2c_master_byte_engine.sv
// I2C master byte engine: the top level joining the front queue, the phase
// sequencer and the result queue. Depends on i2cmbe_pkg and its submodules.
`timescale 1ns / 1ps

// Every item is one tick of the bus timing and carries an optional command
// (start, stop, write byte, read byte with ACK or NACK, wait for ACK) plus the
// sampled SDA level; every item yields exactly one result item with the SCL,
// SDA and SDA enable levels after that tick, the busy and done flags, the last
// received byte and the nack flag. The block takes one item per clock and
// returns one result per clock while neither side stalls: an item waits in a
// two-entry front queue, is consumed combinationally from its head by the
// sequencer, and its result is registered into a two-entry result queue.
// Either side may stall on its own; the queues absorb the difference,
// and full rises only when both queues are backed up. Bus phase lengths are
// counted in items, one microsecond being ticks_per_us items, and a delay too
// long for the DELAY_COUNT_WIDTH counter saturates at its full scale. The
// two configuration registers (index 0 ticks_per_us, index 1 ack_timeout)
// should be written only while no items are in flight. Commands that arrive
// while a sequence runs, including on its final tick, are ignored.
module i2c_master_byte_engine #(
  parameter int DELAY_COUNT_WIDTH = i2cmbe_pkg::DELAY_COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  i2cmbe_pkg::in_item_t  in_item,
  output logic                  empty,
  input  logic                  pop,
  output i2cmbe_pkg::out_item_t out_item,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_wdata
);

  i2cmbe_pkg::tick_chan_t head;
  i2cmbe_pkg::res_chan_t  res;
  logic                   take;
  logic                   res_full;

  i2cmbe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .head    (head),
    .take    (take)
  );

  i2cmbe_seq #(
    .DELAY_COUNT_WIDTH (DELAY_COUNT_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .take      (take),
    .res_full  (res_full),
    .res       (res)
  );

  i2cmbe_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
